>>> rtl/core/pci_bridge_config_space_macros.svh
// assertion helpers, sampled on clk and masked while rst_n is low
`ifndef PCI_BRIDGE_CONFIG_SPACE_MACROS_SVH
`define PCI_BRIDGE_CONFIG_SPACE_MACROS_SVH

// same-cycle implication
`define PCIBCS_AST_IMP(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) else $error(msg);

// next-cycle implication
`define PCIBCS_AST_NXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);

`endif

>>> rtl/core/pcibcs_pkg.sv
`default_nettype none

package pcibcs_pkg;

  typedef struct packed {
    logic       func;
    logic [2:0] function_number;
    logic [7:0] register_address;
    logic [7:0] write_data;
  } req_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [12:0] shadow_read_internal;
    logic [12:0] shadow_write_internal;
    logic [63:0] route_map;
    logic [15:0] level_mask;
    logic [15:0] level_driven;
  } rsp_t;

  // registered read return of the byte store
  typedef struct packed {
    logic [7:0] mem_q;
    logic       vld_q;
    logic [7:0] def_q;
  } rdq_t;

  typedef struct packed {
    logic       en;
    logic [7:0] val;
  } wr_t;

  localparam logic       FUNC_READ  = 1'b0;
  localparam logic       FUNC_WRITE = 1'b1;
  localparam logic [2:0] FN_BRIDGE  = 3'd0;

  localparam logic [7:0] ADDR_CMD     = 8'h04;
  localparam logic [7:0] ADDR_STAT_LO = 8'h06;
  localparam logic [7:0] ADDR_STAT_HI = 8'h07;
  localparam logic [7:0] ADDR_CTRL    = 8'h40;
  localparam logic [7:0] ADDR_LOCK    = 8'h52;
  localparam int         LOCK_BIT     = 2;

  // address[7:2] of the shadow bytes 44..47, address[7:3] of the routing bytes 88..8f
  localparam logic [5:0] SHD_BASE = 6'h11;
  localparam logic [4:0] RT_BASE  = 5'h11;

  localparam logic [7:0] RST_STAT_HI = 8'h02;
  localparam logic [7:0] RST_LOCK    = 8'h06;

  localparam logic [3:0] IRQ_OF_CODE [8] = '{4'd0, 4'd5, 4'd9, 4'd10, 4'd11, 4'd12, 4'd14, 4'd15};

  function automatic logic [7:0] rst_val(input logic [7:0] a);
    logic [7:0] v;
    unique case (a)
      8'h00:        v = 8'h45;
      8'h01:        v = 8'h10;
      8'h02:        v = 8'h22;
      8'h03:        v = 8'hc8;
      ADDR_CMD:     v = 8'h07;
      ADDR_STAT_LO: v = 8'h80;
      ADDR_STAT_HI: v = RST_STAT_HI;
      8'h08:        v = 8'h01;
      8'h0b:        v = 8'h06;
      8'h0d:        v = 8'h20;
      ADDR_CTRL:    v = 8'h01;
      8'h41:        v = 8'h0c;
      8'h43:        v = 8'h02;
      ADDR_LOCK:    v = RST_LOCK;
      8'h53:        v = 8'h90;
      default:      v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] wr_mask(input logic [7:0] a);
    logic [7:0] m;
    unique case (a) inside
      8'h41:                             m = 8'hcf;
      8'h42, 8'h74:                      m = 8'hf8;
      8'h44:                             m = 8'hcb;
      8'h58, 8'h60, 8'h68, 8'h70, 8'h79: m = 8'hfc;
      8'h7f:                             m = 8'h03;
      8'h0d, 8'h43:                      m = 8'hff;
      default: begin
        if ((a >= 8'h45 && a <= 8'h82) || (a >= 8'h84 && a <= 8'h86) ||
            (a >= 8'h88 && a <= 8'h8f)) begin
          m = 8'hff;
        end else begin
          m = 8'h00;
        end
      end
    endcase
    return m;
  endfunction

  function automatic wr_t wr_rule(input logic [7:0] a, input logic [7:0] d,
                                  input logic [7:0] cur07, input logic lock);
    wr_t        r;
    logic [7:0] m;
    m     = wr_mask(a);
    r.en  = 1'b1;
    r.val = d & m;
    unique case (a)
      ADDR_CMD:     r.val = (d & 8'h40) | 8'h07;
      ADDR_STAT_LO: begin
        r.en  = !lock;
        r.val = d & 8'h80;
      end
      ADDR_STAT_HI: r.val = cur07 & ~(d & 8'hf9);
      ADDR_CTRL:    r.val = (d & 8'hc0) | 8'h01;
      default:      r.en  = (m != 8'h00);
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/pcibcs_store.sv
`default_nettype none

module pcibcs_store (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               acc,
  input  pcibcs_pkg::req_t   req,
  output pcibcs_pkg::rdq_t   rdq,
  output logic [31:0]        shd_nxt,
  output logic [63:0]        rt_nxt
);
  import pcibcs_pkg::*;

  logic [7:0]   mem_r [256];
  logic [255:0] vld_r;
  rdq_t         rdq_r;
  logic [7:0]   b07_r, b07_nxt;
  logic         lock_r, lock_nxt;
  logic [31:0]  shd_r;
  logic [63:0]  rt_r;
  logic [7:0]   addr;
  wr_t          wr;
  logic         we;

  assign addr = req.register_address;
  assign wr   = wr_rule(addr, req.write_data, b07_r, lock_r);
  assign we   = acc && (req.func == FUNC_WRITE) && (req.function_number == FN_BRIDGE) && wr.en;
  assign rdq  = rdq_r;

  // register image after this request
  always_comb begin
    b07_nxt  = b07_r;
    lock_nxt = lock_r;
    shd_nxt  = shd_r;
    rt_nxt   = rt_r;
    if (we) begin
      if (addr == ADDR_STAT_HI) begin
        b07_nxt = wr.val;
      end
      if (addr == ADDR_LOCK) begin
        lock_nxt = wr.val[LOCK_BIT];
      end
      if (addr[7:2] == SHD_BASE) begin
        shd_nxt[{addr[1:0], 3'b000} +: 8] = wr.val;
      end
      if (addr[7:3] == RT_BASE) begin
        rt_nxt[{addr[2:0], 3'b000} +: 8] = wr.val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      b07_r  <= RST_STAT_HI;
      lock_r <= RST_LOCK[LOCK_BIT];
      shd_r  <= '0;
      rt_r   <= '0;
    end else begin
      if (we) begin
        vld_r[addr] <= 1'b1;
      end
      b07_r  <= b07_nxt;
      lock_r <= lock_nxt;
      shd_r  <= shd_nxt;
      rt_r   <= rt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wr.val;
    end
    if (acc) begin
      rdq_r.mem_q <= mem_r[addr];
      rdq_r.vld_q <= vld_r[addr];
      rdq_r.def_q <= rst_val(addr);
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/pcibcs_derive.sv
`default_nettype none

module pcibcs_derive (
  input  logic [31:0] shd,
  input  logic [63:0] rt,
  output logic [12:0] sr,
  output logic [12:0] sw,
  output logic [63:0] map,
  output logic [15:0] lvl,
  output logic [15:0] drv
);
  import pcibcs_pkg::*;

  logic [3:0]  nib_w [16];
  logic [3:0]  irq_w [16];
  logic [15:0] n3_w;
  logic [15:0] hit_w [16];
  logic [15:0] sel_w [16];

  genvar i, q;

  // shadow segments: byte 0x47 covers the lowest four
  for (i = 0; i < 12; i++) begin : g_seg
    localparam int BI = (i / 4) ^ 3;
    assign sw[i] = shd[BI * 8 + (i % 4)];
    assign sr[i] = shd[BI * 8 + 4 + (i % 4)];
  end
  assign sw[12] = shd[0];
  assign sr[12] = shd[1];

  for (i = 0; i < 16; i++) begin : g_pin
    localparam int J    = i / 2;
    localparam int K    = J % 2;
    localparam int SLOT = (J / 2) % 4;
    localparam int PIN  = (i % 2 == 1) ? (3 - 2 * K) : (4 - 2 * K);
    localparam int P    = SLOT * 4 + PIN - 1;
    assign nib_w[i]       = rt[J * 8 + (i % 2) * 4 +: 4];
    assign irq_w[i]       = IRQ_OF_CODE[nib_w[i][2:0]];
    assign n3_w[i]        = nib_w[i][3];
    assign map[P * 4 +: 4] = irq_w[i];
  end

  // last nibble in scan order that targets an irq decides its level bit
  for (q = 0; q < 16; q++) begin : g_irq
    for (i = 0; i < 16; i++) begin : g_hit
      assign hit_w[q][i] = (q != 0) && (irq_w[i] == 4'(q));
      assign sel_w[q][i] = hit_w[q][i] && !(|(hit_w[q] >> (i + 1)));
    end
    assign drv[q] = |hit_w[q];
    assign lvl[q] = |(sel_w[q] & n3_w);
  end

endmodule

`default_nettype wire

>>> rtl/core/pci_bridge_config_space.sv
// result path: an accepted request passes the input register, then the result register, before it is offered
// throughput: one request per cycle while the result side keeps up; a held result stalls input
// all derived outputs reflect the registers after the request is applied
// reset (rst_n low, synchronous): channels empty, all bytes back to their defaults at once
`default_nettype none

module pci_bridge_config_space (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pcibcs_pkg::req_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pcibcs_pkg::rsp_t   out_data
);
  import pcibcs_pkg::*;

  `include "pci_bridge_config_space_macros.svh"

  logic        req_v_r, req_v_nxt;
  req_t        req_r;
  logic        out_v_r, out_v_nxt;
  logic        adv, acc;
  logic        rd_fn0_r, rd_oth_r;
  logic [12:0] sr_r, sw_r, sr_w, sw_w;
  logic [63:0] map_r, map_w;
  logic [15:0] lvl_r, drv_r, lvl_w, drv_w;
  rdq_t        rdq;
  logic [31:0] shd_nxt;
  logic [63:0] rt_nxt;

  assign adv      = !out_v_r || out_ready;
  assign acc      = req_v_r && adv;
  assign in_ready = !req_v_r || adv;
  assign out_valid = out_v_r;

  pcibcs_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .req     (req_r),
    .rdq     (rdq),
    .shd_nxt (shd_nxt),
    .rt_nxt  (rt_nxt)
  );

  pcibcs_derive u_derive (
    .shd (shd_nxt),
    .rt  (rt_nxt),
    .sr  (sr_w),
    .sw  (sw_w),
    .map (map_w),
    .lvl (lvl_w),
    .drv (drv_w)
  );

  always_comb begin
    req_v_nxt = req_v_r;
    if (in_valid && in_ready) begin
      req_v_nxt = 1'b1;
    end else if (acc) begin
      req_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (acc) begin
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      req_v_r <= req_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= in_data;
    end
    if (acc) begin
      rd_fn0_r <= (req_r.func == FUNC_READ) && (req_r.function_number == FN_BRIDGE);
      rd_oth_r <= (req_r.func == FUNC_READ) && (req_r.function_number != FN_BRIDGE);
      sr_r     <= sr_w;
      sw_r     <= sw_w;
      map_r    <= map_w;
      lvl_r    <= lvl_w;
      drv_r    <= drv_w;
    end
  end

  always_comb begin
    out_data.read_data = 8'h00;
    if (rd_fn0_r) begin
      out_data.read_data = rdq.vld_q ? rdq.mem_q : rdq.def_q;
    end else if (rd_oth_r) begin
      out_data.read_data = 8'hff;
    end
    out_data.shadow_read_internal  = sr_r;
    out_data.shadow_write_internal = sw_r;
    out_data.route_map             = map_r;
    out_data.level_mask            = lvl_r;
    out_data.level_driven          = drv_r;
  end

  `PCIBCS_AST_NXT(a_req_held, req_v_r && !adv, req_v_r && $stable(req_r), "stalled request lost")
  `PCIBCS_AST_NXT(a_other_fn, acc && req_r.func == FUNC_READ && req_r.function_number != FN_BRIDGE, out_valid && out_data.read_data == 8'hff, "other function read not 0xff")
  `PCIBCS_AST_NXT(a_write_zero, acc && req_r.func == FUNC_WRITE, out_valid && out_data.read_data == 8'h00, "write returned nonzero data")
  `PCIBCS_AST_IMP(a_lvl_driven, out_valid, (out_data.level_mask & ~out_data.level_driven) == 16'h0000, "level mark on undriven irq")
  `PCIBCS_AST_IMP(a_no_irq0, out_valid, !out_data.level_driven[0] && !out_data.level_mask[0], "irq 0 marked")

endmodule

`default_nettype wire

>>> tb/sv/pci_bridge_config_space_chk.sv
`timescale 1ns / 100ps

module pci_bridge_config_space_chk (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  pcibcs_pkg::req_t  in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  pcibcs_pkg::rsp_t  out_data,
  output int                fail_count,
  output int                pending,
  output int                checked
);
  import pcibcs_pkg::*;

  localparam logic [7:0] ADDR_VEN_LO    = 8'h00;
  localparam logic [7:0] ADDR_VEN_HI    = 8'h01;
  localparam logic [7:0] ADDR_DEV_LO    = 8'h02;
  localparam logic [7:0] ADDR_DEV_HI    = 8'h03;
  localparam logic [7:0] ADDR_REV_ID    = 8'h08;
  localparam logic [7:0] ADDR_CLASS     = 8'h0b;
  localparam logic [7:0] ADDR_LAT_TIMER = 8'h0d;
  localparam logic [7:0] ADDR_CTRL1     = 8'h41;
  localparam logic [7:0] ADDR_CTRL2     = 8'h42;
  localparam logic [7:0] ADDR_CTRL3     = 8'h43;
  localparam logic [7:0] ADDR_R53       = 8'h53;
  localparam logic [7:0] ADDR_R58       = 8'h58;
  localparam logic [7:0] ADDR_R60       = 8'h60;
  localparam logic [7:0] ADDR_R68       = 8'h68;
  localparam logic [7:0] ADDR_R70       = 8'h70;
  localparam logic [7:0] ADDR_R74       = 8'h74;
  localparam logic [7:0] ADDR_R79       = 8'h79;
  localparam logic [7:0] ADDR_R7F       = 8'h7f;
  localparam logic [7:0] ADDR_OPEN_LO   = 8'h45;
  localparam logic [7:0] ADDR_OPEN_HI   = 8'h82;
  localparam logic [7:0] ADDR_OPEN2_LO  = 8'h84;
  localparam logic [7:0] ADDR_OPEN2_HI  = 8'h86;
  localparam logic [7:0] ADDR_SHADOW    = {SHD_BASE, 2'b00};
  localparam logic [7:0] ADDR_ROUTE_LO  = {RT_BASE, 3'b000};
  localparam logic [7:0] ADDR_ROUTE_HI  = {RT_BASE, 3'b111};
  localparam logic [7:0] ABSENT_READ    = 8'hff;

  logic [7:0] cfg_mem [256];
  rsp_t       expected_q [$];
  rsp_t       want;
  int         fails = 0;
  int         n_pending = 0;
  int         n_checked = 0;

  assign fail_count = fails;
  assign pending    = n_pending;
  assign checked    = n_checked;

  task automatic load_defaults();
    int i;
    for (i = 0; i < 256; i++) cfg_mem[8'(i)] = 8'h00;
    cfg_mem[ADDR_VEN_LO]    = 8'h45;
    cfg_mem[ADDR_VEN_HI]    = 8'h10;
    cfg_mem[ADDR_DEV_LO]    = 8'h22;
    cfg_mem[ADDR_DEV_HI]    = 8'hc8;
    cfg_mem[ADDR_CMD]       = 8'h07;
    cfg_mem[ADDR_STAT_LO]   = 8'h80;
    cfg_mem[ADDR_STAT_HI]   = 8'h02;
    cfg_mem[ADDR_REV_ID]    = 8'h01;
    cfg_mem[ADDR_CLASS]     = 8'h06;
    cfg_mem[ADDR_LAT_TIMER] = 8'h20;
    cfg_mem[ADDR_CTRL]      = 8'h01;
    cfg_mem[ADDR_CTRL1]     = 8'h0c;
    cfg_mem[ADDR_CTRL3]     = 8'h02;
    cfg_mem[ADDR_LOCK]      = 8'h06;
    cfg_mem[ADDR_R53]       = 8'h90;
  endtask

  function automatic logic [7:0] byte_mask(input logic [7:0] a);
    case (a)
      ADDR_CTRL1:                                   return 8'hcf;
      ADDR_CTRL2, ADDR_R74:                         return 8'hf8;
      ADDR_SHADOW:                                  return 8'hcb;
      ADDR_R58, ADDR_R60, ADDR_R68, ADDR_R70, ADDR_R79: return 8'hfc;
      ADDR_R7F:                                     return 8'h03;
      ADDR_LAT_TIMER, ADDR_CTRL3:                   return 8'hff;
      default: ;
    endcase
    if ((a >= ADDR_OPEN_LO && a <= ADDR_OPEN_HI) ||
        (a >= ADDR_OPEN2_LO && a <= ADDR_OPEN2_HI) ||
        (a >= ADDR_ROUTE_LO && a <= ADDR_ROUTE_HI)) return 8'hff;
    return 8'h00;
  endfunction

  task automatic store_byte(input logic [7:0] a, input logic [7:0] d);
    logic [7:0] m;
    m = byte_mask(a);
    case (a)
      ADDR_CMD:     cfg_mem[a] = (d & 8'h40) | 8'h07;
      ADDR_STAT_LO: if (!cfg_mem[ADDR_LOCK][LOCK_BIT]) cfg_mem[a] = d & 8'h80;
      ADDR_STAT_HI: cfg_mem[a] = cfg_mem[a] & ~(d & 8'hf9);
      ADDR_CTRL:    cfg_mem[a] = (d & 8'hc0) | 8'h01;
      default:      if (m != 8'h00) cfg_mem[a] = d & m;
    endcase
  endtask

  function automatic logic [3:0] irq_for_code(input logic [2:0] code);
    case (code)
      3'd0:    return 4'd0;
      3'd1:    return 4'd5;
      3'd2:    return 4'd9;
      3'd3:    return 4'd10;
      3'd4:    return 4'd11;
      3'd5:    return 4'd12;
      3'd6:    return 4'd14;
      default: return 4'd15;
    endcase
  endfunction

  // outputs derived from the bytes as they stand after the request
  function automatic rsp_t derive_outputs(input logic [7:0] rd);
    rsp_t       r;
    logic [7:0] sb;
    logic [7:0] rb;
    logic [3:0] nib;
    logic [3:0] irq;
    int         i;
    int         b;
    int         k;
    int         slot;
    int         pin;
    int         p;
    r = '0;
    r.read_data = rd;
    for (i = 0; i < 12; i++) begin
      sb = cfg_mem[8'(ADDR_SHADOW + ((i >> 2) ^ 3))];
      r.shadow_write_internal[4'(i)] = sb[3'(i % 4)];
      r.shadow_read_internal[4'(i)]  = sb[3'(4 + i % 4)];
    end
    sb = cfg_mem[ADDR_SHADOW];
    r.shadow_write_internal[12] = sb[0];
    r.shadow_read_internal[12]  = sb[1];
    for (i = 0; i < 16; i++) begin
      b    = i >> 1;
      rb   = cfg_mem[8'(ADDR_ROUTE_LO + b)];
      nib  = (i % 2 == 1) ? rb[7:4] : rb[3:0];
      irq  = irq_for_code(nib[2:0]);
      k    = b % 2;
      slot = (b & 6) >> 1;
      pin  = (i % 2 == 1) ? (3 - 2 * k) : (4 - 2 * k);
      p    = slot * 4 + pin - 1;
      r.route_map[6'(p * 4) +: 4] = irq;
      if (irq != 4'd0) begin
        r.level_driven[irq] = 1'b1;
        r.level_mask[irq]   = nib[3];
      end
    end
    return r;
  endfunction

  task automatic apply_request(input req_t q, output rsp_t r);
    logic [7:0] rd;
    rd = 8'h00;
    if (q.func == FUNC_WRITE) begin
      if (q.function_number == FN_BRIDGE) store_byte(q.register_address, q.write_data);
    end else begin
      rd = (q.function_number == FN_BRIDGE) ? cfg_mem[q.register_address] : ABSENT_READ;
    end
    r = derive_outputs(rd);
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %h, actual %h", name, exp_v, act_v);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      load_defaults();
      expected_q.delete();
      n_pending = 0;
    end else begin
      if (in_valid && in_ready) begin
        apply_request(in_data, want);
        expected_q.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("result with no request outstanding");
          fails++;
        end else begin
          want = expected_q.pop_front();
          check_field("read_data", 64'(want.read_data), 64'(out_data.read_data));
          check_field("shadow_read_internal", 64'(want.shadow_read_internal),
                      64'(out_data.shadow_read_internal));
          check_field("shadow_write_internal", 64'(want.shadow_write_internal),
                      64'(out_data.shadow_write_internal));
          check_field("route_map", want.route_map, out_data.route_map);
          check_field("level_mask", 64'(want.level_mask), 64'(out_data.level_mask));
          check_field("level_driven", 64'(want.level_driven),
                      64'(out_data.level_driven));
          n_checked++;
        end
      end
      n_pending = expected_q.size();
    end
  end

endmodule

>>> tb/sv/pci_bridge_config_space_tb.sv
`timescale 1ns / 100ps

module pci_bridge_config_space_tb;
  import pcibcs_pkg::*;

  localparam int RANDOM_PER_PHASE = 550;
  localparam int CYCLE_LIMIT      = 200000;
  localparam int DRAIN_CYCLES     = 6;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  req_t in_data;
  logic out_valid;
  logic out_ready;
  rsp_t out_data;

  int send_idle_pct;
  int recv_idle_pct;
  int cycles = 0;
  int n_sent;
  int n_writes;
  int n_absent;
  int fail_count;
  int pending;
  int checked;
  int i;

  always #1 clk = ~clk;

  pci_bridge_config_space u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  pci_bridge_config_space_chk u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic req_t access_of(input logic f, input logic [2:0] fn,
                                     input logic [7:0] a, input logic [7:0] d);
    req_t q;
    q.func             = f;
    q.function_number  = fn;
    q.register_address = a;
    q.write_data       = d;
    return q;
  endfunction

  function automatic req_t random_request();
    req_t q;
    int   pick;
    q.func = ($urandom_range(0, 1) == 1) ? FUNC_WRITE : FUNC_READ;
    q.function_number = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(1, 7)) : FN_BRIDGE;
    q.write_data = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      q.register_address = {SHD_BASE, 2'($urandom_range(0, 3))};
    end else if (pick < 35) begin
      q.register_address = {RT_BASE, 3'($urandom_range(0, 7))};
    end else if (pick < 50) begin
      case ($urandom_range(0, 4))
        0:       q.register_address = ADDR_CMD;
        1:       q.register_address = ADDR_STAT_LO;
        2:       q.register_address = ADDR_STAT_HI;
        3:       q.register_address = ADDR_CTRL;
        default: q.register_address = ADDR_LOCK;
      endcase
    end else if (pick < 70) begin
      q.register_address = 8'($urandom_range(ADDR_CTRL, {RT_BASE, 3'b111}));
    end else begin
      q.register_address = 8'($urandom_range(0, 255));
    end
    return q;
  endfunction

  // valid stays high between back-to-back requests
  task automatic send_request(input req_t q);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= q;
    do @(posedge clk); while (!in_ready);
    n_sent++;
    if (q.func == FUNC_WRITE) n_writes++;
    if (q.function_number != FN_BRIDGE) n_absent++;
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_ready     = 1'b0;
    send_idle_pct = 24;
    recv_idle_pct = 77;
    n_sent        = 0;
    n_writes      = 0;
    n_absent      = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // field extremes, absent function, read-only bytes
    send_request(access_of(FUNC_READ, FN_BRIDGE, '0, '0));
    send_request(access_of(FUNC_READ, FN_BRIDGE, '1, '1));
    send_request(access_of(FUNC_READ, '1, ADDR_CMD, '0));
    send_request(access_of(FUNC_WRITE, FN_BRIDGE, '0, '1));
    send_request(access_of(FUNC_WRITE, FN_BRIDGE, '1, '0));
    send_request(access_of(FUNC_WRITE, FN_BRIDGE, ADDR_CMD, '1));
    // status low byte while locked, then unlocked; then status high and control bytes
    send_request(access_of(FUNC_WRITE, FN_BRIDGE, ADDR_STAT_LO, '0));
    send_request(access_of(FUNC_WRITE, 3'd5, ADDR_LOCK, '0));
    send_request(access_of(FUNC_READ, FN_BRIDGE, ADDR_STAT_LO, '0));
    send_request(access_of(FUNC_WRITE, FN_BRIDGE, ADDR_LOCK, '0));
    send_request(access_of(FUNC_WRITE, FN_BRIDGE, ADDR_STAT_LO, '0));
    send_request(access_of(FUNC_WRITE, FN_BRIDGE, ADDR_STAT_LO, '1));
    send_request(access_of(FUNC_READ, FN_BRIDGE, ADDR_STAT_LO, '0));
    send_request(access_of(FUNC_WRITE, FN_BRIDGE, ADDR_STAT_HI, '1));
    send_request(access_of(FUNC_WRITE, FN_BRIDGE, ADDR_CTRL, '1));
    // shadow enables
    send_request(access_of(FUNC_WRITE, FN_BRIDGE, {SHD_BASE, 2'b00}, '1));
    send_request(access_of(FUNC_WRITE, FN_BRIDGE, {SHD_BASE, 2'b11}, '1));
    // every pin to the same irq (15), then the last routing byte drops its level mark
    for (i = 0; i < 8; i++) begin
      send_request(access_of(FUNC_WRITE, FN_BRIDGE, {RT_BASE, 3'(i)}, '1));
    end
    send_request(access_of(FUNC_WRITE, FN_BRIDGE, {RT_BASE, 3'b111}, 8'h07));
    wait_results();

    repeat (RANDOM_PER_PHASE) send_request(random_request());
    send_idle_pct = 77;
    recv_idle_pct = 24;
    repeat (RANDOM_PER_PHASE) send_request(random_request());
    wait_results();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (RANDOM_PER_PHASE) send_request(random_request());

    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d requests (%0d writes, %0d to absent functions), %0d results compared",
             n_sent, n_writes, n_absent, checked);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/pcibcs_pkg.sv
rtl/core/pcibcs_store.sv
rtl/core/pcibcs_derive.sv
rtl/core/pci_bridge_config_space.sv
tb/sv/pci_bridge_config_space_chk.sv
tb/sv/pci_bridge_config_space_tb.sv
